// ===== hdl/mbe_pkg.sv =====
`default_nettype none
package mbe_pkg;

  // Number formats
  localparam int FRAC_BITS  = 26;
  localparam int COUNT_BITS = 16;
  localparam int MAX_DIM    = 4096;
  localparam int FIX_W      = 32;
  localparam int COORD_W    = 12;
  localparam int WIDTH_W    = 13;
  localparam int INDEX_W    = 24;
  localparam int CFG_IDX_W  = 3;

  // Offset product: unsigned pixel index times signed step
  localparam int PRE_W  = COORD_W + 1 + FIX_W;
  // Running z: offset product plus origin, and headroom for the update
  localparam int Z_W    = PRE_W + 1;
  // A z that has passed the magnitude test lies within [-2.0, 2.0]
  localparam int MUL_W  = FRAC_BITS + 3;
  localparam int PROD_W = 2 * MUL_W;
  localparam int IDX_PROD_W = COORD_W + WIDTH_W;

  // 2.0 in the z format, 4.0 in the squared format
  localparam logic signed [Z_W-1:0] TWO_FIX =
    {{(Z_W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [PROD_W-1:0] FOUR_SQ =
    {{(PROD_W-2*FRAC_BITS-3){1'b0}}, 1'b1, {(2*FRAC_BITS+2){1'b0}}};
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(MAX_DIM);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_RE = 3'd0,
    CFG_ORIGIN_IM = 3'd1,
    CFG_STEP_RE   = 3'd2,
    CFG_STEP_IM   = 3'd3,
    CFG_WIDTH     = 3'd4,
    CFG_MAX_ITER  = 3'd5
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic start;    // take the input word
    logic setup;    // form offset and row products
    logic load_c;   // form c, seed z, clear count
    logic square;   // form z products
    logic update;   // step z and the count
    logic capture;  // load the output register
  } mbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_limit; // count has reached the limit
    logic big;      // a component of z exceeds 2.0
    logic outside;  // |z|^2 exceeds 4.0
  } mbe_sts_t;

endpackage
`default_nettype wire

// ===== hdl/mbe_ctrl.sv =====
`default_nettype none
module mbe_ctrl import mbe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire mbe_sts_t sts,
  output mbe_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_LOAD   = 6'b000100,
    S_SQUARE = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Issue commands
  always_comb begin
    cmd         = '0;
    cmd.start   = (state_r == S_IDLE) && in_valid;
    cmd.setup   = (state_r == S_SETUP);
    cmd.load_c  = (state_r == S_LOAD);
    cmd.square  = (state_r == S_SQUARE);
    cmd.update  = (state_r == S_UPDATE) && !sts.outside;
    cmd.capture = (state_r == S_FINISH) && slot_free;
  end

  // Sequence one pixel
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_SQUARE;
      S_SQUARE: begin
        if (sts.at_limit || sts.big) state_nxt = S_FINISH;
        else                         state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.outside) state_nxt = S_FINISH;
        else             state_nxt = S_SQUARE;
      end
      S_FINISH: if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture)    out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mbe_dp.sv =====
`default_nettype none
module mbe_dp import mbe_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIX_W-1:0]     cfg_data,
  input  wire logic [COORD_W-1:0]   in_column,
  input  wire logic [COORD_W-1:0]   in_row,
  input  wire mbe_cmd_t             cmd,
  output mbe_sts_t                  sts,
  output logic [COUNT_BITS-1:0]     out_iterations,
  output logic [INDEX_W-1:0]        out_pixel_index
);

  // Configuration
  logic signed [FIX_W-1:0] origin_re_r, origin_im_r, step_re_r, step_im_r;
  logic [WIDTH_W-1:0]      width_r;
  logic [COUNT_BITS-1:0]   max_iter_r;

  // Pixel and working values
  logic [COORD_W-1:0]      col_r, row_r;
  logic signed [PRE_W-1:0] pre_re_r, pre_im_r;
  logic [IDX_PROD_W-1:0]   idx_prod_r;
  logic [INDEX_W-1:0]      idx_r;
  logic signed [Z_W-1:0]   c_re_r, c_im_r, z_re_r, z_im_r;
  logic signed [PROD_W-1:0] rr_r, ii_r, ri_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic [COUNT_BITS-1:0]   out_iter_r;
  logic [INDEX_W-1:0]      out_idx_r;

  logic [WIDTH_W-1:0]       width_eff;
  logic signed [MUL_W-1:0]  zr_m, zi_m;
  logic signed [PROD_W-1:0] sq_sum, sq_diff, ri_twice;
  logic [IDX_PROD_W-1:0]    idx_sum;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= '0;
      origin_im_r <= '0;
      step_re_r   <= '0;
      step_im_r   <= '0;
      width_r     <= WIDTH_W'(1);
      max_iter_r  <= COUNT_BITS'(256);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_RE: origin_re_r <= cfg_data;
        CFG_ORIGIN_IM: origin_im_r <= cfg_data;
        CFG_STEP_RE:   step_re_r   <= cfg_data;
        CFG_STEP_IM:   step_im_r   <= cfg_data;
        CFG_WIDTH:     width_r     <= cfg_data[WIDTH_W-1:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the row length
  assign width_eff = (width_r > MAX_WIDTH) ? MAX_WIDTH : width_r;

  // Square operands: only meaningful once the magnitude test has passed
  assign zr_m     = z_re_r[MUL_W-1:0];
  assign zi_m     = z_im_r[MUL_W-1:0];
  assign sq_sum   = rr_r + ii_r;
  assign sq_diff  = rr_r - ii_r;
  assign ri_twice = {ri_r[PROD_W-2:0], 1'b0};
  assign idx_sum  = idx_prod_r + IDX_PROD_W'(col_r);

  // Report status
  assign sts.at_limit = (count_r == max_iter_r);
  assign sts.big      = (z_re_r > TWO_FIX) || (z_re_r < -TWO_FIX) ||
                        (z_im_r > TWO_FIX) || (z_im_r < -TWO_FIX);
  assign sts.outside  = (sq_sum > FOUR_SQ);

  always_ff @(posedge clk) begin
    // Take the pixel
    if (cmd.start) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    // Offset products and row base
    if (cmd.setup) begin
      pre_re_r   <= $signed({1'b0, col_r}) * step_re_r;
      pre_im_r   <= $signed({1'b0, row_r}) * step_im_r;
      idx_prod_r <= row_r * width_eff;
    end
    // Form c and seed z
    if (cmd.load_c) begin
      c_re_r <= Z_W'(origin_re_r) + Z_W'(pre_re_r);
      c_im_r <= Z_W'(origin_im_r) + Z_W'(pre_im_r);
      z_re_r <= Z_W'(origin_re_r) + Z_W'(pre_re_r);
      z_im_r <= Z_W'(origin_im_r) + Z_W'(pre_im_r);
      idx_r  <= idx_sum[INDEX_W-1:0];
    end
    // Square z
    if (cmd.square) begin
      rr_r <= zr_m * zr_m;
      ii_r <= zi_m * zi_m;
      ri_r <= zr_m * zi_m;
    end
    // Advance z, flooring the fraction
    if (cmd.update) begin
      z_re_r <= c_re_r + Z_W'(sq_diff >>> FRAC_BITS);
      z_im_r <= c_im_r + Z_W'(ri_twice >>> FRAC_BITS);
    end
    // Load the result word
    if (cmd.capture) begin
      out_iter_r <= count_r;
      out_idx_r  <= idx_r;
    end
  end

  // Round count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load_c) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_r + COUNT_BITS'(1);
    end
  end

  assign out_iterations  = out_iter_r;
  assign out_pixel_index = out_idx_r;

endmodule
`default_nettype wire

// ===== hdl/mandelbrot_escape_time.sv =====
`default_nettype none
// Mandelbrot escape-time unit.
// Configuration: write a register on cfg_valid with cfg_index and cfg_data;
// cfg_ready is always high. Registers 0..3 are origin and step (signed
// Q5.26), 4 the row length, 5 the round limit. Write only while idle.
// Input: one word per pixel (in_column, in_row) on in_valid/in_ready.
// in_ready is high only while no pixel is in work; one pixel at a time.
// Output: out_iterations and out_pixel_index on out_valid/out_ready.
// From input accept the unit steps through setup and load, then the rounds,
// each a squaring state (multiply) and an update state (add, compare and
// step) through the squaring unit. The limit or the component test stops the
// loop in the squaring state, the |z|^2 test in the update state; a finish
// state then loads the output word. in_ready rises in the cycle after the
// word is loaded.
// A finished word waits in the output register; the next pixel is accepted
// and worked on meanwhile, and stalls only at its own finish until the
// register is taken.
// Reset (synchronous, rst_n low) empties the unit and restores the
// registers: origin and step 0, row length 1, limit 256.
module mandelbrot_escape_time import mbe_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIX_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [COORD_W-1:0]   in_column,
  input  wire logic [COORD_W-1:0]   in_row,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COUNT_BITS-1:0]     out_iterations,
  output logic [INDEX_W-1:0]        out_pixel_index
);

  mbe_cmd_t cmd;
  mbe_sts_t sts;

  assign cfg_ready = 1'b1;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbe_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_column       (in_column),
    .in_row          (in_row),
    .cmd             (cmd),
    .sts             (sts),
    .out_iterations  (out_iterations),
    .out_pixel_index (out_pixel_index)
  );

`ifndef NO_ASSERTIONS
  // One pixel at a time: an accepted word closes the input
  a_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a pixel is in work");

  // Never overwrite a result word that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result word overwritten");

  // A step of z follows a squaring and stays within the limit
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!sts.at_limit && $past(cmd.square)))
    else $error("z stepped out of order or past the limit");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mbe_pkg::*;

  localparam int ONE_FIX         = 1 << FRAC_BITS;
  localparam int RANDOM_PHASES   = 20;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 32;
  localparam int CYCLE_LIMIT     = 5_000_000;

  // Register indexes that map to nothing in the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [COUNT_BITS-1:0] iterations;
    logic [INDEX_W-1:0]    pixel_index;
  } pixel_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIX_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   in_column = '0;
  logic [COORD_W-1:0]   in_row = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COUNT_BITS-1:0] out_iterations;
  logic [INDEX_W-1:0]   out_pixel_index;

  // Local copy of the view registers, at their reset values
  logic signed [FIX_W-1:0] view_origin_re = '0;
  logic signed [FIX_W-1:0] view_origin_im = '0;
  logic signed [FIX_W-1:0] view_step_re = '0;
  logic signed [FIX_W-1:0] view_step_im = '0;
  logic [WIDTH_W-1:0]      view_width = 1;
  logic [COUNT_BITS-1:0]   view_limit = 256;

  pixel_word_t pixels_in_flight[$];
  bit          idle_on = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  mandelbrot_escape_time u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_column       (in_column),
    .in_row          (in_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_iterations  (out_iterations),
    .out_pixel_index (out_pixel_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Escape count and linear index of one pixel under the current view
  function automatic pixel_word_t predict_pixel(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row);
    longint      c_re, c_im, z_re, z_im, rr, ii, ri;
    longint      two_fix, four_sq;
    int unsigned rounds, row_len;
    pixel_word_t word;
    two_fix = longint'(2) << FRAC_BITS;
    four_sq = longint'(1) << (2 * FRAC_BITS + 2);
    c_re = longint'(view_origin_re) + longint'(col) * longint'(view_step_re);
    c_im = longint'(view_origin_im) + longint'(row) * longint'(view_step_im);
    z_re = c_re;
    z_im = c_im;
    rounds = 0;
    while (rounds < view_limit) begin
      // a component beyond 2.0 has escaped; this also keeps the squares small
      if ((z_re < 0 ? -z_re : z_re) > two_fix || (z_im < 0 ? -z_im : z_im) > two_fix)
        break;
      rr = z_re * z_re;
      ii = z_im * z_im;
      if (rr + ii > four_sq)
        break;
      ri = 2 * z_re * z_im;
      // arithmetic shift drops the low bits, rounding toward minus infinity
      z_re = c_re + ((rr - ii) >>> FRAC_BITS);
      z_im = c_im + (ri >>> FRAC_BITS);
      rounds++;
    end
    row_len = (view_width > MAX_DIM) ? MAX_DIM : view_width;
    word.iterations = rounds[COUNT_BITS-1:0];
    word.pixel_index = INDEX_W'(row * row_len + col);
    return word;
  endfunction

  // Offer one pixel word, wait for it to be taken and record its result
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_column <= col;
    in_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_in_flight.push_back(predict_pixel(col, row));
  endtask

  // Drop the input word and let every outstanding result come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight.size() != 0) @(posedge clk);
  endtask

  // Write one register; valid stays high so that writes can follow back to back
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ORIGIN_RE: view_origin_re = data;
      CFG_ORIGIN_IM: view_origin_im = data;
      CFG_STEP_RE:   view_step_re = data;
      CFG_STEP_IM:   view_step_im = data;
      CFG_WIDTH:     view_width = data[WIDTH_W-1:0];
      CFG_MAX_ITER:  view_limit = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Wait for the block to go quiet, then write the whole view
  task automatic load_view(input logic [FIX_W-1:0] ore, input logic [FIX_W-1:0] oim,
                           input logic [FIX_W-1:0] sre, input logic [FIX_W-1:0] sim,
                           input logic [FIX_W-1:0] wreg, input logic [FIX_W-1:0] lim);
    drain_pixels();
    cfg_write(CFG_ORIGIN_RE, ore);
    cfg_write(CFG_ORIGIN_IM, oim);
    cfg_write(CFG_STEP_RE, sre);
    cfg_write(CFG_STEP_IM, sim);
    cfg_write(CFG_WIDTH, wreg);
    cfg_write(CFG_MAX_ITER, lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    // c is zero at reset, so every pixel runs to the limit of 256
    send_pixel('0, '0);
    send_pixel('1, '1);
  endtask

  task automatic test_escape_boundaries();
    // c = -2 lands on z = 2 and stays there
    load_view(-2 * ONE_FIX, 0, 0, 0, MAX_DIM, 300);
    send_pixel('0, '0);
    send_pixel('1, '1);
    // c = 2: a component equal to 2.0 passes, the next z is 6
    load_view(2 * ONE_FIX, 0, 0, 0, MAX_DIM, 50);
    send_pixel(1, 2);
    // both components below 2.0 but |z|^2 = 4.5
    load_view(3 * ONE_FIX / 2, 3 * ONE_FIX / 2, 0, 0, 16, 50);
    send_pixel(3, 1);
    // extreme origin and step, c far outside; width clamps to the maximum
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, 32'hFFFF_0014);
    send_pixel('1, '1);
    send_pixel('0, '0);
    // opposite signs, and a width of zero leaves the column alone
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 5);
    send_pixel('1, '1);
  endtask

  task automatic test_limits();
    // zero limit: no round at all, even far outside
    load_view(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 1, 0);
    send_pixel('1, 7);
    send_pixel('0, '1);
    // upper data bits dropped: width 10, limit 3; column beyond the width
    load_view(0, 0, 0, 0, 32'hFFFF_E00A, 32'hABCD_0003);
    send_pixel('1, 3);
    // slow escape near the neck of the set
    load_view(-3 * ONE_FIX / 4, ONE_FIX / 20, 0, 0, 10, 1000);
    send_pixel(9, 2);
    // full count width: c = 0 runs all 65535 rounds
    load_view(0, 0, 0, 0, MAX_DIM, 16'hFFFF);
    send_pixel(7, 7);
  endtask

  task automatic test_ignored_registers();
    // c = 0.25 creeps toward 0.5 and never escapes
    load_view(ONE_FIX / 4, 0, 0, 0, 100, 40);
    send_pixel(5, 6);
    drain_pixels();
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, 32'h8000_0000);
    cfg_valid <= 1'b0;
    send_pixel(5, 6);
  endtask

  task automatic test_random_views();
    int unsigned        kind, span_col, span_row;
    logic [FIX_W-1:0]   ore, oim, sre, sim, wreg, lim;
    logic [COORD_W-1:0] col, row;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = $urandom_range(0, 9);
      span_col = $urandom_range(4, 48);
      span_row = $urandom_range(4, 48);
      if (kind == 0)
        span_col = $urandom_range(49, MAX_DIM);
      lim = $urandom_range(0, 80);
      if (kind == 1)
        lim = 256;
      if (kind <= 6) begin
        // whole-set view with a jittered corner
        ore = -(2 * ONE_FIX + ONE_FIX / 5) + int'($urandom_range(0, ONE_FIX / 2));
        oim = -(3 * ONE_FIX / 2) + int'($urandom_range(0, ONE_FIX / 4));
        sre = (3 * ONE_FIX) / int'(span_col);
        sim = (3 * ONE_FIX) / int'(span_row);
        wreg = span_col;
      end else if (kind <= 8) begin
        // raw register contents, mostly far outside
        ore = $urandom;
        oim = $urandom;
        sre = $urandom;
        sim = $urandom;
        wreg = $urandom;
        lim = $urandom_range(0, 300);
      end else begin
        // zoom onto the boundary near the neck
        ore = -(3 * ONE_FIX / 4) - int'($urandom_range(0, ONE_FIX / 64));
        oim = ONE_FIX / 32 + int'($urandom_range(0, ONE_FIX / 64));
        sre = $urandom_range(1, ONE_FIX >> 10);
        sim = $urandom_range(1, ONE_FIX >> 10);
        wreg = span_col;
        lim = $urandom_range(40, 200);
      end
      idle_on = (phase < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
      load_view(ore, oim, sre, sim, wreg, lim);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off once mid-phase until the block has emptied
        if (phase == RANDOM_PHASES / 2 && k == ITEMS_PER_PHASE / 2)
          drain_pixels();
        if ($urandom_range(0, 6) == 0) begin
          col = $urandom;
          row = $urandom;
        end else begin
          col = $urandom_range(0, span_col - 1);
          row = $urandom_range(0, span_row - 1);
        end
        send_pixel(col, row);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_reset_values();
    test_escape_boundaries();
    test_limits();
    test_ignored_registers();
    test_random_views();
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest outstanding pixel
  always @(posedge clk) begin : check_results
    pixel_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_in_flight.size() == 0) begin
        $error("result word with no pixel outstanding: iterations %0d, pixel_index %0d",
               out_iterations, out_pixel_index);
        errors++;
      end else begin
        want = pixels_in_flight.pop_front();
        if (out_iterations !== want.iterations) begin
          $error("iterations: expected %0d, got %0d", want.iterations, out_iterations);
          errors++;
        end
        if (out_pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index, out_pixel_index);
          errors++;
        end
      end
    end
  end

  // Abandon a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule

// ===== mandelbrot_escape_time.f =====
hdl/mbe_pkg.sv
hdl/mbe_ctrl.sv
hdl/mbe_dp.sv
hdl/mandelbrot_escape_time.sv
test/tb.sv
